// ===== hw/rtl/ssbr_pkg.sv =====
// ssbr_pkg: shared types, constants and byte helpers of the split stream byte realigner
// used by ssbr_front, ssbr_queue, ssbr_back and split_stream_byte_realigner
`timescale 1ns / 1ps

package ssbr_pkg;

    localparam int WORD_BYTES = 8;
    localparam int DATA_W     = 8 * WORD_BYTES;
    localparam int CNT_W      = 4;
    localparam int OFF_W      = 3;
    localparam int QUEUE_AW   = 2;
    localparam int QUEUE_DEPTH = 1 << QUEUE_AW;
    localparam logic [WORD_BYTES-1:0] FULL_KEEP = 8'hFF;

    typedef enum logic
    {
        K_PASS,
        K_MERGE
    } kind_t;

    typedef struct packed
    {
        kind_t                  kind;
        logic                   join_first;
        logic [DATA_W-1:0]      data;
        logic [DATA_W-1:0]      prev;
        logic [OFF_W-1:0]       off;
        logic [CNT_W-1:0]       cnt;
        logic [WORD_BYTES-1:0]  keep;
        logic                   last;
    } q_entry_t;

    function automatic logic [CNT_W-1:0] count_bytes(input logic [WORD_BYTES-1:0] keep);
        logic [CNT_W-1:0] n;
        logic             run;
        n   = '0;
        run = 1'b1;
        for (int i = 0; i < WORD_BYTES; i++)
        begin
            run = run & keep[i];
            if (run)
            begin
                n = n + 1'b1;
            end
        end
        return n;
    endfunction

    function automatic logic [WORD_BYTES-1:0] keep_of(input logic [CNT_W-1:0] n);
        logic [WORD_BYTES-1:0] k;
        if (n >= CNT_W'(WORD_BYTES))
        begin
            k = FULL_KEEP;
        end
        else
        begin
            k = (WORD_BYTES'(1) << n[OFF_W-1:0]) - WORD_BYTES'(1);
        end
        return k;
    endfunction

    function automatic logic [DATA_W-1:0] low_bytes(input logic [DATA_W-1:0] x,
                                                    input logic [OFF_W-1:0] n);
        logic [DATA_W-1:0] m;
        m = (DATA_W'(1) << {n, 3'b000}) - DATA_W'(1);
        return x & m;
    endfunction

    function automatic logic [DATA_W-1:0] shl_bytes(input logic [DATA_W-1:0] x,
                                                    input logic [OFF_W-1:0] n);
        return x << {n, 3'b000};
    endfunction

    function automatic logic [DATA_W-1:0] shr_bytes(input logic [DATA_W-1:0] x,
                                                    input logic [CNT_W-1:0] n);
        logic [DATA_W-1:0] r;
        if (n >= CNT_W'(WORD_BYTES))
        begin
            r = '0;
        end
        else
        begin
            r = x >> {n[OFF_W-1:0], 3'b000};
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/ssbr_front.sv =====
// ssbr_front: accepts input items, tracks the segment phase and the held word,
// and classifies the items into queue entries (a held partial word makes none); depends on ssbr_pkg
`timescale 1ns / 1ps

module ssbr_front
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [ssbr_pkg::DATA_W-1:0]    word_data,
    input  logic [ssbr_pkg::WORD_BYTES-1:0] word_keep,
    input  logic                           word_last,
    input  logic                           split_flag,
    input  logic                           q_full,
    output logic                           push,
    output ssbr_pkg::q_entry_t             push_entry
);
    import ssbr_pkg::*;

    typedef enum logic [2:0]
    {
        PH_IDLE,
        PH_STREAM,
        PH_UNMERGED,
        PH_JOIN,
        PH_MERGED
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic                split_reg, split_next;
    logic [DATA_W-1:0]   held_reg, held_next;
    logic [OFF_W-1:0]    off_reg, off_next;
    logic                accept;
    logic                split_eff;
    logic [CNT_W-1:0]    cnt;

    assign in_ready = !q_full;
    assign accept   = in_valid && !q_full;
    assign cnt      = count_bytes(word_keep);

    always_comb
    begin
        phase_next = phase_reg;
        split_next = split_reg;
        held_next  = held_reg;
        off_next   = off_reg;
        push       = 1'b0;
        split_eff  = (phase_reg == PH_STREAM) ? split_reg : split_flag;
        push_entry.kind = K_PASS;
        push_entry.join_first = 1'b0;
        push_entry.data = word_data;
        push_entry.prev = held_reg;
        push_entry.off  = off_reg;
        push_entry.cnt  = cnt;
        push_entry.keep = word_keep;
        push_entry.last = word_last;
        if (accept)
        begin
            case (phase_reg)
                PH_UNMERGED:
                begin
                    push = 1'b1;
                    if (word_last)
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                PH_JOIN, PH_MERGED:
                begin
                    push = 1'b1;
                    push_entry.kind = K_MERGE;
                    push_entry.join_first = (phase_reg == PH_JOIN);
                    held_next  = word_data;
                    phase_next = word_last ? PH_IDLE : PH_MERGED;
                end
                default:
                begin
                    if (phase_reg != PH_STREAM)
                    begin
                        split_next = split_flag;
                    end
                    if (word_last && split_eff)
                    begin
                        if (cnt == CNT_W'(WORD_BYTES))
                        begin
                            push = 1'b1;
                            push_entry.last = 1'b0;
                            phase_next = PH_UNMERGED;
                        end
                        else
                        begin
                            held_next  = word_data;
                            off_next   = cnt[OFF_W-1:0];
                            phase_next = PH_JOIN;
                        end
                    end
                    else
                    begin
                        push = 1'b1;
                        phase_next = word_last ? PH_IDLE : PH_STREAM;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            split_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            split_reg <= split_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_reg <= held_next;
        off_reg  <= off_next;
    end

endmodule

// ===== hw/rtl/ssbr_queue.sv =====
// ssbr_queue: short register queue of classified entries between front and back
// depends on ssbr_pkg
`timescale 1ns / 1ps

module ssbr_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  ssbr_pkg::q_entry_t  push_entry,
    output logic                full,
    input  logic                pop,
    output logic                head_valid,
    output ssbr_pkg::q_entry_t  head
);
    import ssbr_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    q_entry_t              entries_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]         count_reg;

    assign full       = (count_reg == CW'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entries_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== hw/rtl/ssbr_back.sv =====
// ssbr_back: takes queue entries, does the byte shifting and drives the output register,
// including the residue word; depends on ssbr_pkg
`timescale 1ns / 1ps

module ssbr_back
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            head_valid,
    input  ssbr_pkg::q_entry_t              head,
    output logic                            pop,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [ssbr_pkg::DATA_W-1:0]     out_data,
    output logic [ssbr_pkg::WORD_BYTES-1:0] out_keep,
    output logic                            out_last,
    output logic                            run_end
);
    import ssbr_pkg::*;

    logic                   valid_reg;
    logic [DATA_W-1:0]      data_reg;
    logic [WORD_BYTES-1:0]  keep_reg;
    logic                   last_reg, end_reg;
    logic                   pend_reg;
    logic [DATA_W-1:0]      res_data_reg;
    logic [WORD_BYTES-1:0]  res_keep_reg;

    logic                   can_load;
    logic [CNT_W-1:0]       back_off;
    logic [CNT_W-1:0]       sum;
    logic [DATA_W-1:0]      cur;
    logic [DATA_W-1:0]      r0_data;
    logic [WORD_BYTES-1:0]  r0_keep;
    logic                   r0_last, two;

    assign can_load = !valid_reg || out_ready;
    assign pop      = can_load && !pend_reg && head_valid;
    assign back_off = CNT_W'(WORD_BYTES) - {1'b0, head.off};
    assign sum      = head.cnt + {1'b0, head.off};

    always_comb
    begin
        cur = (head.join_first ? low_bytes(head.prev, head.off)
                               : shr_bytes(head.prev, back_off))
              | shl_bytes(head.data, head.off);
        r0_data = head.data;
        r0_keep = head.keep;
        r0_last = head.last;
        two     = 1'b0;
        case (head.kind)
            K_MERGE:
            begin
                r0_data = cur;
                if (head.last && (sum <= CNT_W'(WORD_BYTES)))
                begin
                    r0_keep = keep_of(sum);
                    r0_last = 1'b1;
                end
                else
                begin
                    r0_keep = FULL_KEEP;
                    r0_last = 1'b0;
                    two     = head.last;
                end
            end
            default:
            begin
                r0_data = head.data;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else if (can_load)
        begin
            if (pend_reg)
            begin
                valid_reg <= 1'b1;
                pend_reg  <= 1'b0;
            end
            else
            begin
                valid_reg <= head_valid;
                pend_reg  <= head_valid && two;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (can_load)
        begin
            if (pend_reg)
            begin
                data_reg <= res_data_reg;
                keep_reg <= res_keep_reg;
                last_reg <= 1'b1;
                end_reg  <= 1'b1;
            end
            else
            begin
                data_reg     <= r0_data;
                keep_reg     <= r0_keep;
                last_reg     <= r0_last;
                end_reg      <= !two;
                res_data_reg <= shr_bytes(head.data, back_off);
                res_keep_reg <= keep_of(sum - CNT_W'(WORD_BYTES));
            end
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign out_keep  = keep_reg;
    assign out_last  = last_reg;
    assign run_end   = end_reg;

endmodule

// ===== hw/rtl/split_stream_byte_realigner.sv =====
// split_stream_byte_realigner: top level, front classifier, entry queue and shifting back end
// depends on ssbr_pkg, ssbr_front, ssbr_queue and ssbr_back
//
// channel   direction  signals                       contents
// s_axis    in         tvalid tready tdata tlast tuser  data words, keep, burst last, split flag
// m_axis    out        tvalid tready tdata tlast tuser  realigned words, keep, segment last, run end
//
// one item a cycle while neither side stalls; the partial last word of a split first part gives
// no result, and a closing word that overflows the held bytes gives two results: the full word
// and then the residue. an item is registered in the queue entry, then in the output register.
// rst_n clears the phase, the queue pointers and the output valid; held data needs no reset.
// the front stalls only on a full four-entry queue; the back on m_axis_tready or a residue word.
`timescale 1ns / 1ps

module split_stream_byte_realigner
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // word_data[63:0], word_keep[71:64]
    input  logic        s_axis_tlast,
    input  logic [0:0]  s_axis_tuser,   // split_flag
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // out_data[63:0], out_keep[71:64]
    output logic        m_axis_tlast,
    output logic [0:0]  m_axis_tuser    // run_end
);
    import ssbr_pkg::*;

    logic      q_full, push, pop, head_valid;
    q_entry_t  push_entry, head;

    ssbr_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .word_data  (s_axis_tdata[63:0]),
        .word_keep  (s_axis_tdata[71:64]),
        .word_last  (s_axis_tlast),
        .split_flag (s_axis_tuser[0]),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    ssbr_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    ssbr_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_data   (m_axis_tdata[63:0]),
        .out_keep   (m_axis_tdata[71:64]),
        .out_last   (m_axis_tlast),
        .run_end    (m_axis_tuser[0])
    );

endmodule

// ===== tb/testbench.sv =====
// testbench: directed and random word streams into split_stream_byte_realigner, every output
// item checked field by field against an in-bench model of the byte realignment
// depends on ssbr_pkg and split_stream_byte_realigner
`timescale 1ns / 1ps

module testbench;

    import ssbr_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int HOLD_AT      = 300;
    localparam int HOLD_CYCLES  = 120;
    localparam int RANDOM_WORDS = 1250;

    typedef enum logic [2:0]
    {
        SEG_IDLE,
        SEG_PASS,
        SEG_SECOND_RAW,
        SEG_JOIN,
        SEG_MERGE
    } seg_phase_t;

    typedef enum logic [1:0]
    {
        SINK_FLOW,
        SINK_RANDOM,
        SINK_PATTERN,
        SINK_HOLD
    } sink_mode_t;

    typedef struct packed
    {
        logic [DATA_W-1:0]     data;
        logic [WORD_BYTES-1:0] keep;
        logic                  burst_last;
        logic                  split;
        logic                  drain;
    } src_word_t;

    typedef struct packed
    {
        logic [DATA_W-1:0]     data;
        logic [WORD_BYTES-1:0] keep;
        logic                  seg_last;
        logic                  run_end;
    } out_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata = '0;     // word_data[63:0], word_keep[71:64]
    logic        s_axis_tlast = 1'b0;
    logic [0:0]  s_axis_tuser = '0;     // split_flag
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;          // out_data[63:0], out_keep[71:64]
    logic        m_axis_tlast;
    logic [0:0]  m_axis_tuser;          // run_end

    src_word_t   source_words[$];
    out_word_t   expected_words[$];
    int          words_queued = 0;
    int          mismatches = 0;

    seg_phase_t            seg_phase = SEG_IDLE;
    logic                  seg_split = 1'b0;
    logic [DATA_W-1:0]     held_data = '0;
    int                    held_bytes = 0;

    int          burst_left;
    int          gap_left;
    logic        src_stalled;
    sink_mode_t  sink_mode = SINK_FLOW;
    int          sink_left;
    int          sink_cycles;
    int          sink_pick;
    out_word_t   want;
    int          idle_cycles = 0;

    split_stream_byte_realigner dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #4 clk = ~clk;

    function automatic logic [WORD_BYTES-1:0] ones_keep(input int n);
        return ~(8'hFF << n);
    endfunction

    // expected output items for one accepted input item
    function automatic void realign_word(input src_word_t w);
        out_word_t         made [2];
        int                n_made;
        int                cnt;
        int                off;
        logic [DATA_W-1:0] joined;
        n_made = 0;
        cnt = 0;
        while (cnt < WORD_BYTES && w.keep[cnt])
        begin
            cnt++;
        end
        case (seg_phase)
            SEG_JOIN, SEG_MERGE:
            begin
                off = held_bytes;
                if (seg_phase == SEG_JOIN)
                begin
                    joined = held_data & ~({DATA_W{1'b1}} << (8 * off));
                end
                else
                begin
                    joined = held_data >> (8 * (WORD_BYTES - off));
                end
                joined = joined | (w.data << (8 * off));
                held_data = w.data;
                if (!w.burst_last)
                begin
                    made[0] = '{joined, FULL_KEEP, 1'b0, 1'b0};
                    n_made = 1;
                    seg_phase = SEG_MERGE;
                end
                else
                begin
                    if (cnt + off <= WORD_BYTES)
                    begin
                        made[0] = '{joined, ones_keep(cnt + off), 1'b1, 1'b0};
                        n_made = 1;
                    end
                    else
                    begin
                        // closing word overflows the held bytes: full word plus residue
                        made[0] = '{joined, FULL_KEEP, 1'b0, 1'b0};
                        made[1] = '{held_data >> (8 * (WORD_BYTES - off)),
                                    ones_keep(cnt + off - WORD_BYTES), 1'b1, 1'b0};
                        n_made = 2;
                    end
                    seg_phase = SEG_IDLE;
                end
            end
            SEG_SECOND_RAW:
            begin
                made[0] = '{w.data, w.keep, w.burst_last, 1'b0};
                n_made = 1;
                if (w.burst_last)
                begin
                    seg_phase = SEG_IDLE;
                end
            end
            default:
            begin
                if (seg_phase != SEG_PASS)
                begin
                    seg_split = w.split;
                end
                if (w.burst_last && seg_split)
                begin
                    if (cnt == WORD_BYTES)
                    begin
                        made[0] = '{w.data, w.keep, 1'b0, 1'b0};
                        n_made = 1;
                        seg_phase = SEG_SECOND_RAW;
                    end
                    else
                    begin
                        held_data = w.data;
                        held_bytes = cnt;
                        seg_phase = SEG_JOIN;
                    end
                end
                else
                begin
                    made[0] = '{w.data, w.keep, w.burst_last, 1'b0};
                    n_made = 1;
                    seg_phase = w.burst_last ? SEG_IDLE : SEG_PASS;
                end
            end
        endcase
        for (int i = 0; i < n_made; i++)
        begin
            if (i == n_made - 1)
            begin
                made[i].run_end = 1'b1;
            end
            expected_words.push_back(made[i]);
        end
    endfunction

    function automatic void queue_word(input logic [DATA_W-1:0] d, input logic [7:0] k,
                                       input logic l, input logic s);
        source_words.push_back('{d, k, l, s, 1'b0});
        words_queued++;
    endfunction

    function automatic void queue_drain();
        source_words.push_back('{'0, '0, 1'b0, 1'b0, 1'b1});
    endfunction

    // one memory burst: full words, then a closing word with the given keep
    function automatic void queue_burst(input int n, input logic [7:0] end_keep,
                                        input logic split);
        for (int i = 0; i < n; i++)
        begin
            queue_word({$urandom, $urandom}, (i == n - 1) ? end_keep : FULL_KEEP,
                       i == n - 1, (i == 0) ? split : 1'($urandom_range(0, 1)));
        end
    endfunction

    function automatic int burst_len();
        int r;
        r = $urandom_range(0, 7);
        if (r < 5)
        begin
            return $urandom_range(1, 4);
        end
        if (r < 7)
        begin
            return $urandom_range(5, 8);
        end
        return $urandom_range(9, 16);
    endfunction

    function automatic logic [7:0] pick_keep();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
        begin
            return 8'($urandom_range(0, 255));
        end
        if (r == 1)
        begin
            return FULL_KEEP;
        end
        return ones_keep($urandom_range(0, 8));
    endfunction

    initial
    begin
        int  random_start;
        int  pick;
        bit  mid_drained;
        mid_drained = 1'b0;

        // extremes, pass-through, unmerged, residue, exact fit, empty and scattered keep
        queue_word({DATA_W{1'b1}}, FULL_KEEP, 1'b1, 1'b0);
        queue_word('0, 8'h01, 1'b1, 1'b0);
        queue_burst(2, FULL_KEEP, 1'b1);
        queue_burst(2, 8'h0F, 1'b1);
        queue_burst(2, 8'h07, 1'b1);
        queue_burst(2, 8'h3F, 1'b0);
        queue_burst(1, 8'h1F, 1'b1);
        queue_burst(1, 8'h07, 1'b0);
        queue_burst(1, 8'h00, 1'b1);
        queue_burst(2, 8'h7F, 1'b0);
        queue_word({$urandom, $urandom}, 8'hA5, 1'b1, 1'b0);
        queue_burst(1, 8'h0D, 1'b1);
        queue_word({$urandom, $urandom}, 8'h00, 1'b0, 1'b0);
        queue_word({$urandom, $urandom}, FULL_KEEP, 1'b1, 1'b1);
        queue_burst(1, 8'h7F, 1'b1);
        queue_burst(1, FULL_KEEP, 1'b0);
        queue_drain();

        random_start = words_queued;
        while (words_queued - random_start < RANDOM_WORDS)
        begin
            if (!mid_drained && words_queued - random_start >= RANDOM_WORDS / 2)
            begin
                queue_drain();
                mid_drained = 1'b1;
            end
            pick = $urandom_range(0, 9);
            if (pick < 6)
            begin
                queue_burst(burst_len(), pick_keep(), 1'b1);
                queue_burst(burst_len(), pick_keep(), 1'($urandom_range(0, 1)));
            end
            else if (pick < 9)
            begin
                queue_burst(burst_len(), pick_keep(), 1'b0);
            end
            else
            begin
                pick = $urandom_range(1, 3);
                for (int i = 0; i < pick; i++)
                begin
                    queue_word({$urandom, $urandom}, 8'($urandom_range(0, 255)),
                               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                end
            end
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (source_words.size() != 0 || s_axis_tvalid || expected_words.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // sender: bursts of random length with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end
        else
        begin
            src_stalled = s_axis_tvalid && !s_axis_tready;
            if (s_axis_tvalid && s_axis_tready)
            begin
                realign_word(source_words.pop_front());
            end
            if (!src_stalled)
            begin
                if (source_words.size() != 0 && source_words[0].drain
                    && expected_words.size() == 0)
                begin
                    void'(source_words.pop_front());
                end
                if (gap_left != 0 || source_words.size() == 0 || source_words[0].drain)
                begin
                    s_axis_tvalid <= 1'b0;
                    if (gap_left != 0)
                    begin
                        gap_left--;
                    end
                end
                else
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {source_words[0].keep, source_words[0].data};
                    s_axis_tlast  <= source_words[0].burst_last;
                    s_axis_tuser  <= source_words[0].split;
                    if (burst_left == 0)
                    begin
                        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 120)
                                                                  : $urandom_range(1, 6);
                    end
                    burst_left--;
                    if (burst_left == 0)
                    begin
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
            end
        end
    end

    // receiver: stall pattern of its own, one forced long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            sink_left = 0;
            sink_cycles = 0;
        end
        else
        begin
            sink_cycles++;
            if (sink_cycles == HOLD_AT)
            begin
                sink_mode = SINK_HOLD;
                sink_left = HOLD_CYCLES;
            end
            else if (sink_left == 0)
            begin
                sink_pick = $urandom_range(0, 15);
                if (sink_pick < 6)
                begin
                    sink_mode = SINK_FLOW;
                end
                else if (sink_pick < 11)
                begin
                    sink_mode = SINK_RANDOM;
                end
                else if (sink_pick < 15)
                begin
                    sink_mode = SINK_PATTERN;
                end
                else
                begin
                    sink_mode = SINK_HOLD;
                end
                sink_left = (sink_mode == SINK_HOLD) ? $urandom_range(20, 80)
                                                     : $urandom_range(5, 60);
            end
            sink_left--;
            case (sink_mode)
                SINK_FLOW:    m_axis_tready <= 1'b1;
                SINK_RANDOM:  m_axis_tready <= 1'($urandom_range(0, 1));
                SINK_PATTERN: m_axis_tready <= (sink_left % 3 == 0);
                default:      m_axis_tready <= 1'b0;
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_words.size() == 0)
            begin
                $error("out item with none expected: data %h keep %h",
                       m_axis_tdata[63:0], m_axis_tdata[71:64]);
                mismatches++;
            end
            else
            begin
                want = expected_words.pop_front();
                if (m_axis_tdata[63:0] !== want.data)
                begin
                    $error("out_data: expected %h, actual %h", want.data, m_axis_tdata[63:0]);
                    mismatches++;
                end
                if (m_axis_tdata[71:64] !== want.keep)
                begin
                    $error("out_keep: expected %h, actual %h", want.keep, m_axis_tdata[71:64]);
                    mismatches++;
                end
                if (m_axis_tlast !== want.seg_last)
                begin
                    $error("out_last: expected %b, actual %b", want.seg_last, m_axis_tlast);
                    mismatches++;
                end
                if (m_axis_tuser[0] !== want.run_end)
                begin
                    $error("run_end: expected %b, actual %b", want.run_end, m_axis_tuser[0]);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

endmodule
